>>> sv/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache tag store.
// Used by every module of the block; depends on nothing else.
package salc_pkg;

  localparam int ADDR_W     = 64;
  localparam int WAYS       = 8;
  localparam int SETS       = 128;
  localparam int LINE_BYTES = 32;

  localparam int OFFS_W = $clog2(LINE_BYTES);
  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int RANK_W = $clog2(WAYS);
  localparam int TAG_W  = ADDR_W - OFFS_W - SET_W;

  localparam logic [WAY_W-1:0]  LastWay  = WAY_W'(WAYS - 1);
  localparam logic [RANK_W-1:0] TopRank  = RANK_W'(WAYS - 1);

  // One set of the tag store: all ways side by side.
  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0]              dirty;
    logic [WAYS-1:0][RANK_W-1:0]  rank;
    logic [WAYS-1:0][TAG_W-1:0]   tag;
  } row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Sequencer controls toward the datapath.
  typedef struct packed {
    logic             in_ready;
    logic             start;
    logic             step;
    logic [WAY_W-1:0] idx;
    logic             commit;
  } ctrl_t;

  // Outcome of the way scan.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
  } scan_t;

  // One result item.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
    logic             writeback;
    logic [TAG_W-1:0] victim_tag;
  } res_t;

endpackage

>>> sv/set_assoc_lru_cache_tags_core.sv
// Top level of the set-associative LRU cache tag store.
// Depends on salc_pkg, salc_tag_ram, salc_way_scan, salc_update and salc_ctrl.
//
// Usage:
//   Access channel: in_valid_i/in_ready_o carry opcode_i (0 read, 1 write) and
//   the 64-bit byte address_i. Result channel: out_valid_o/out_ready_i carry
//   hit, way, evicted, writeback and victim_tag, one result per access.
//   A transfer on the access channel reads the whole set from the tag RAM.
//   The shared tag comparator and victim tracker then step over the eight
//   ways, one per cycle, and a final commit step writes the updated set back
//   and loads the result register. A new access waits until the last one
//   commits; in_ready_o is low while an access is in progress.
//   If the receiver stalls, the finished result waits in the output register
//   and a following access holds in its commit cycle until the slot frees.
//   Reset clears the per-set init bits, so every line reads invalid, clean,
//   with tag and rank zero; no clearing pass is needed and the block is
//   ready as soon as reset is released.
module set_assoc_lru_cache_tags_core
  import salc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [WAY_W-1:0]  way_o,
  output logic              evicted_o,
  output logic              writeback_o,
  output logic [TAG_W-1:0]  victim_tag_o
);

  ctrl_t            ctrl;
  scan_t            scan;
  row_t             row;
  row_t             new_row;
  res_t             res;
  logic             out_free;

  logic             write_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  logic             out_valid_q, out_valid_d;
  res_t             res_q;

  assign out_free = !out_valid_q || out_ready_i;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  salc_tag_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ctrl.start),
    .rd_addr_i (address_i[OFFS_W +: SET_W]),
    .rd_row_o  (row),
    .wr_en_i   (ctrl.commit),
    .wr_addr_i (set_q),
    .wr_row_i  (new_row)
  );

  salc_way_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .row_i  (row),
    .tag_i  (tag_q),
    .scan_o (scan)
  );

  salc_update u_update (
    .row_i   (row),
    .scan_i  (scan),
    .tag_i   (tag_q),
    .write_i (write_q),
    .row_o   (new_row),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      write_q <= opcode_i;
      set_q   <= address_i[OFFS_W +: SET_W];
      tag_q   <= address_i[ADDR_W-1 -: TAG_W];
    end
    if (ctrl.commit) begin
      res_q <= res;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = ctrl.in_ready;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = res_q.hit;
  assign way_o        = res_q.way;
  assign evicted_o    = res_q.evicted;
  assign writeback_o  = res_q.writeback;
  assign victim_tag_o = res_q.victim_tag;

`ifndef SYNTHESIS
  // An accepted access keeps the block busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("access accepted while a previous one is in progress");

  // A commit returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> in_ready_o && out_valid_o)
    else $error("commit did not complete the access");

  // A hit never reports an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o && !writeback_o && victim_tag_o == '0)
    else $error("hit result carries eviction information");

  // A writeback is only reported for an evicted line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_o |-> evicted_o)
    else $error("writeback without eviction");
`endif

endmodule

>>> sv/salc_tag_ram.sv
// Tag store memory: one row per set, registered read, one write port.
// A per-set init bit makes rows that were never written read as all zero.
// Depends on salc_pkg.
module salc_tag_ram
  import salc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_addr_i,
  output row_t             rd_row_o,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_addr_i,
  input  row_t             wr_row_i
);

  row_t            mem [SETS];
  row_t            rd_data_q;
  logic [SETS-1:0] init_q;
  logic            rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        init_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_init_q ? rd_data_q : '0;

endmodule

>>> sv/salc_way_scan.sv
// Shared tag compare and victim tracker, stepped over the ways one per cycle.
// Depends on salc_pkg.
module salc_way_scan
  import salc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  row_t             row_i,
  input  logic [TAG_W-1:0] tag_i,
  output scan_t            scan_o
);

  logic              hit_q, hit_d;
  logic [WAY_W-1:0]  hit_way_q, hit_way_d;
  logic [WAY_W-1:0]  victim_q, victim_d;
  logic              have_inv_q, have_inv_d;
  logic              have_cand_q, have_cand_d;
  logic [RANK_W-1:0] best_q, best_d;

  logic              way_valid;
  logic [RANK_W-1:0] way_rank;
  logic              match;

  assign way_valid = row_i.valid[ctrl_i.idx];
  assign way_rank  = row_i.rank[ctrl_i.idx];
  assign match     = way_valid && (row_i.tag[ctrl_i.idx] == tag_i);

  always_comb begin
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    victim_d    = victim_q;
    have_inv_d  = have_inv_q;
    have_cand_d = have_cand_q;
    best_d      = best_q;
    if (ctrl_i.start) begin
      hit_d       = 1'b0;
      hit_way_d   = '0;
      victim_d    = '0;
      have_inv_d  = 1'b0;
      have_cand_d = 1'b0;
      best_d      = '0;
    end else if (ctrl_i.step) begin
      if (match && !hit_q) begin
        hit_d     = 1'b1;
        hit_way_d = ctrl_i.idx;
      end
      // The last invalid way wins; otherwise the first way of lowest rank.
      if (!way_valid) begin
        victim_d   = ctrl_i.idx;
        have_inv_d = 1'b1;
      end else if (!have_inv_q && (!have_cand_q || way_rank < best_q)) begin
        victim_d    = ctrl_i.idx;
        have_cand_d = 1'b1;
        best_d      = way_rank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      hit_way_q   <= '0;
      victim_q    <= '0;
      have_inv_q  <= 1'b0;
      have_cand_q <= 1'b0;
      best_q      <= '0;
    end else begin
      hit_q       <= hit_d;
      hit_way_q   <= hit_way_d;
      victim_q    <= victim_d;
      have_inv_q  <= have_inv_d;
      have_cand_q <= have_cand_d;
      best_q      <= best_d;
    end
  end

  assign scan_o.hit     = hit_q;
  assign scan_o.hit_way = hit_way_q;
  assign scan_o.victim  = victim_q;

endmodule

>>> sv/salc_update.sv
// Builds the updated set row and the result item from the scan outcome.
// Depends on salc_pkg.
module salc_update
  import salc_pkg::*;
(
  input  row_t             row_i,
  input  scan_t            scan_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic             write_i,
  output row_t             row_o,
  output res_t             res_o
);

  logic [WAY_W-1:0]  w;
  logic [RANK_W-1:0] old_rank;
  logic              old_valid;

  assign w         = scan_i.hit ? scan_i.hit_way : scan_i.victim;
  assign old_rank  = row_i.rank[w];
  assign old_valid = row_i.valid[w];

  always_comb begin
    row_o = row_i;
    // Move the touched way to most recent; ways ranked above it drop by one.
    for (int i = 0; i < WAYS; i++) begin
      if (row_i.rank[i] > old_rank) begin
        row_o.rank[i] = row_i.rank[i] - RANK_W'(1);
      end
    end
    row_o.rank[w] = TopRank;
    if (scan_i.hit) begin
      row_o.dirty[w] = row_i.dirty[w] | write_i;
    end else begin
      row_o.valid[w] = 1'b1;
      row_o.dirty[w] = write_i;
      row_o.tag[w]   = tag_i;
    end
  end

  always_comb begin
    res_o.hit        = scan_i.hit;
    res_o.way        = w;
    res_o.evicted    = !scan_i.hit && old_valid;
    res_o.writeback  = !scan_i.hit && old_valid && row_i.dirty[w];
    res_o.victim_tag = (!scan_i.hit && old_valid) ? row_i.tag[w] : '0;
  end

endmodule

>>> sv/salc_ctrl.sv
// Sequencer: accepts an access, steps the way scan, then commits the set.
// Depends on salc_pkg.
module salc_ctrl
  import salc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e           state_q, state_d;
  logic [WAY_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + WAY_W'(1);
        if (idx_q == LastWay) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.start    = in_valid_i;
      end
      ST_SCAN: begin
        ctrl_o.step = 1'b1;
      end
      ST_UPDATE: begin
        ctrl_o.commit = out_free_i;
      end
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the set-associative LRU cache tag store.
// Predicts hit, way and eviction results from its own tag, dirty and rank
// tables and compares them per transfer. Depends on salc_pkg and the core.
module tb;
  import salc_pkg::*;

  localparam int LINES     = WAYS * SETS;
  localparam int HOLD_LEN  = 300;
  localparam int LIMIT     = 400000;
  localparam int DRAIN_CYC = 30;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              opcode_i;
  logic [ADDR_W-1:0] address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              hit_o;
  logic [WAY_W-1:0]  way_o;
  logic              evicted_o;
  logic              writeback_o;
  logic [TAG_W-1:0]  victim_tag_o;

  set_assoc_lru_cache_tags_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .way_o        (way_o),
    .evicted_o    (evicted_o),
    .writeback_o  (writeback_o),
    .victim_tag_o (victim_tag_o)
  );

  // Shadow copy of the tag store, indexed by set * WAYS + way.
  bit              line_valid_sh [LINES];
  bit              line_dirty_sh [LINES];
  bit [TAG_W-1:0]  line_tag_sh   [LINES];
  bit [RANK_W-1:0] line_rank_sh  [LINES];

  res_t expected_results [$];

  logic [TAG_W-1:0] tag_pool [16];
  logic [SET_W-1:0] hot_sets [4];

  bit in_idle_en;
  bit out_stall_en;
  bit hold_req;

  int err_count;
  int access_count;
  int hit_count;
  int miss_count;
  int evict_count;
  int wb_count;
  int cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The touched way becomes most recent; ways ranked above its old rank move down.
  function automatic void promote_way(input int base, input int w);
    bit [RANK_W-1:0] old_rank;
    old_rank = line_rank_sh[base + w];
    for (int i = 0; i < WAYS; i++) begin
      if (line_rank_sh[base + i] > old_rank) begin
        line_rank_sh[base + i] = line_rank_sh[base + i] - 1'b1;
      end
    end
    line_rank_sh[base + w] = TopRank;
  endfunction

  function automatic res_t predict_access(input logic op, input logic [ADDR_W-1:0] addr);
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    int               base;
    int               victim;
    int               best_rank;
    bit               have_invalid;
    res_t             r;
    set_idx      = addr[OFFS_W +: SET_W];
    tag          = addr[ADDR_W-1 -: TAG_W];
    base         = int'(set_idx) * WAYS;
    r            = '0;
    victim       = 0;
    best_rank    = WAYS;
    have_invalid = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (line_valid_sh[base + w] && line_tag_sh[base + w] == tag) begin
        if (op) line_dirty_sh[base + w] = 1'b1;
        promote_way(base, w);
        r.hit = 1'b1;
        r.way = WAY_W'(w);
        return r;
      end
    end
    // Highest invalid way wins; otherwise the lowest rank, lowest way on a tie.
    for (int w = 0; w < WAYS; w++) begin
      if (!line_valid_sh[base + w]) begin
        victim       = w;
        have_invalid = 1'b1;
      end else if (!have_invalid && int'(line_rank_sh[base + w]) < best_rank) begin
        victim    = w;
        best_rank = int'(line_rank_sh[base + w]);
      end
    end
    if (line_valid_sh[base + victim]) begin
      r.evicted    = 1'b1;
      r.writeback  = line_dirty_sh[base + victim];
      r.victim_tag = line_tag_sh[base + victim];
    end
    line_valid_sh[base + victim] = 1'b1;
    line_dirty_sh[base + victim] = op;
    line_tag_sh[base + victim]   = tag;
    promote_way(base, victim);
    r.way = WAY_W'(victim);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [SET_W-1:0] set_idx,
                                                  input logic [OFFS_W-1:0] offs);
    return {tag, set_idx, offs};
  endfunction

  // Offers one access and records its expected result once the transfer happens.
  // Valid stays high afterwards so back-to-back accesses need no extra edge.
  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    opcode_i   <= op;
    address_i  <= addr;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_access(op, addr));
    access_count++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_accesses();
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
    send_access(1'b0, '0);
    send_access(1'b0, '0);
    send_access(1'b1, '1);
    send_access(1'b0, '1);
    // Fill the rest of set 0 from the top invalid way down.
    for (int t = 1; t < WAYS; t++) begin
      send_access(1'(t), make_addr(TAG_W'(t), '0, OFFS_W'(t * 3)));
    end
    send_access(1'b1, make_addr(TAG_W'(1), '0, '1));
    send_access(1'b0, make_addr(TAG_W'(8), '0, '0));
    // Differs from an allocated tag only in the top bit, so it must miss.
    send_access(1'b0, make_addr({1'b1, (TAG_W-1)'(0)}, '0, '0));
    // Push the dirty all-ones line out of the last set.
    for (int t = 1; t <= WAYS; t++) begin
      send_access(1'b0, make_addr(TAG_W'(t), '1, OFFS_W'($urandom)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    logic [ADDR_W-1:0] addr;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        addr = {$urandom, $urandom};
      end else if (pick < 30) begin
        addr = make_addr(tag_pool[$urandom_range(0, 15)], SET_W'($urandom),
                         OFFS_W'($urandom));
      end else begin
        addr = make_addr(tag_pool[$urandom_range(0, 10)], hot_sets[$urandom_range(0, 3)],
                         OFFS_W'($urandom));
      end
      send_access(1'($urandom), addr);
    end
  endtask

  task automatic test_mixed_traffic();
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
    test_random_traffic(1500);
    drain_results();
  endtask

  // The receiver holds off while accesses keep coming, so the core backs up.
  task automatic test_output_backpressure();
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    hold_req     = 1'b1;
    test_random_traffic(40);
    drain_results();
  endtask

  task automatic test_full_rate();
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    test_random_traffic(300);
    drain_results();
  endtask

  initial begin : ready_driver
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (out_stall_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no access outstanding");
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (hit_o !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, hit_o);
          err_count++;
        end
        if (way_o !== exp_r.way) begin
          $error("way: expected %0d, got %0d", exp_r.way, way_o);
          err_count++;
        end
        if (evicted_o !== exp_r.evicted) begin
          $error("evicted: expected %0d, got %0d", exp_r.evicted, evicted_o);
          err_count++;
        end
        if (writeback_o !== exp_r.writeback) begin
          $error("writeback: expected %0d, got %0d", exp_r.writeback, writeback_o);
          err_count++;
        end
        if (victim_tag_o !== exp_r.victim_tag) begin
          $error("victim_tag: expected %h, got %h", exp_r.victim_tag, victim_tag_o);
          err_count++;
        end
        if (exp_r.hit) hit_count++;
        else miss_count++;
        if (exp_r.evicted) evict_count++;
        if (exp_r.writeback) wb_count++;
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = 1'b0;
    address_i    = '0;
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    hold_req     = 1'b0;
    err_count    = 0;
    access_count = 0;
    hit_count    = 0;
    miss_count   = 0;
    evict_count  = 0;
    wb_count     = 0;
    cycle_count  = 0;
    tag_pool[0]  = '0;
    tag_pool[1]  = '1;
    for (int i = 2; i < 16; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_W'($urandom);
    hot_sets[3] = SET_W'($urandom);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_accesses();
    test_mixed_traffic();
    test_output_backpressure();
    test_full_rate();

    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("Ran %0d accesses: %0d hits and %0d misses.", access_count, hit_count,
             miss_count);
    $display("Misses evicted %0d valid lines, %0d of them dirty.", evict_count, wb_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
